// ===== hdl/ddcl_pkg.sv =====
// Package for the debounced digit code lock.
// Holds lane count, config register codes, result types and the segment table.
// No dependencies.
package ddcl_pkg;

	// number of button lanes (1..8)
	localparam int NUM_DIGITS = 3;
	// lanes that have a button pin, code digit and result field
	localparam int BTN_LANES = 3;
	// digit array width covering both the lanes and the code digits
	localparam int PAD_DIGITS = (NUM_DIGITS > BTN_LANES) ? NUM_DIGITS : BTN_LANES;

	localparam int DIGIT_W = 4;
	localparam int TIME_W = 32;
	localparam int DEB_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef digit_t [NUM_DIGITS-1:0] digits_t;
	typedef digit_t [PAD_DIGITS-1:0] pad_digits_t;
	typedef digit_t [BTN_LANES-1:0] code_t;

	// reset values of the config registers
	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd20;
	localparam digit_t CODE_FIRST_RST = 4'd9;
	localparam digit_t CODE_SECOND_RST = 4'd6;
	localparam digit_t CODE_THIRD_RST = 4'd7;
	localparam logic PRESSED_RST = 1'b0;
	localparam digit_t DIGIT_LAST = 4'd9;

	// config register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 3'd0,
		REG_CODE_FIRST = 3'd1,
		REG_CODE_SECOND = 3'd2,
		REG_CODE_THIRD = 3'd3,
		REG_PRESSED = 3'd4
	} cfg_reg_t;

	// config state
	typedef struct packed {
		logic [DEB_W-1:0] debounce_ms;
		code_t code;
		logic pressed_level;
	} cfg_t;

	// what one lane would do if it gets to run
	typedef struct packed {
		digit_t digit_nxt;
		logic press;
	} lane_prop_t;

	typedef lane_prop_t [NUM_DIGITS-1:0] lane_props_t;

	// one result word as stored in the output buffer
	typedef struct packed {
		code_t digits;
		logic unlocked;
		logic [BTN_LANES-1:0] press_seen;
	} res_t;

	// digits equal the configured code (missing lanes read as zero)
	function automatic logic code_match(pad_digits_t d, code_t c);
		logic m;
		m = 1'b1;
		for (int k = 0; k < BTN_LANES; k++) begin
			m = m & (d[k] == c[k]);
		end
		return m;
	endfunction

	// seven-segment pattern, bit 0 is segment a
	function automatic logic [6:0] seg_of(digit_t d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== hdl/debounced_digit_code_lock.sv =====
// Top level of the debounced digit code lock: config registers, lanes,
// merge stage and a two-word output buffer. Depends on ddcl_pkg,
// ddcl_lane and ddcl_merge.
//
//  channel | signals                                   | word
//  --------+-------------------------------------------+-------------------------
//  in      | in_valid, in_ready                        | now_ms, button_levels
//  out     | out_valid, out_ready                      | digits, segs, unlocked,
//          |                                           | press_seen
//  cfg     | cfg_valid, cfg_ready (always 1)           | cfg_index, cfg_data
//
// One word per cycle while in_ready is high: all lanes debounce in parallel
// and the ordered merge commits their state in the cycle the input word is
// accepted. The result is registered into the head word of the two-word
// output buffer, or into the skid word while the head is held, so input flows
// on while one result waits; in_ready drops only when both buffer words are held.
// Reset clears lane state, config to defaults and the buffer.
module debounced_digit_code_lock (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ddcl_pkg::TIME_W-1:0]       now_ms,
	input  logic [2:0]                        button_levels,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [3:0]                        digit_zero,
	output logic [3:0]                        digit_one,
	output logic [3:0]                        digit_two,
	output logic [6:0]                        segs_zero,
	output logic [6:0]                        segs_one,
	output logic [6:0]                        segs_two,
	output logic                              unlocked,
	output logic [2:0]                        press_seen,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ddcl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ddcl_pkg::CFG_DATA_W-1:0]   cfg_data
);

	ddcl_pkg::cfg_t                    cfg_q;
	ddcl_pkg::digits_t                 digits;
	ddcl_pkg::lane_props_t             props;
	logic [ddcl_pkg::NUM_DIGITS-1:0]   en;
	ddcl_pkg::res_t                    res;
	ddcl_pkg::res_t                    head_q;
	ddcl_pkg::res_t                    skid_q;
	logic                              head_vld_q;
	logic                              skid_vld_q;
	logic                              push;
	logic                              pop;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= ddcl_pkg::DEBOUNCE_RST;
			cfg_q.code[0] <= ddcl_pkg::CODE_FIRST_RST;
			cfg_q.code[1] <= ddcl_pkg::CODE_SECOND_RST;
			cfg_q.code[2] <= ddcl_pkg::CODE_THIRD_RST;
			cfg_q.pressed_level <= ddcl_pkg::PRESSED_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ddcl_pkg::REG_DEBOUNCE: cfg_q.debounce_ms <= cfg_data[ddcl_pkg::DEB_W-1:0];
				ddcl_pkg::REG_CODE_FIRST: cfg_q.code[0] <= cfg_data[ddcl_pkg::DIGIT_W-1:0];
				ddcl_pkg::REG_CODE_SECOND: cfg_q.code[1] <= cfg_data[ddcl_pkg::DIGIT_W-1:0];
				ddcl_pkg::REG_CODE_THIRD: cfg_q.code[2] <= cfg_data[ddcl_pkg::DIGIT_W-1:0];
				ddcl_pkg::REG_PRESSED: cfg_q.pressed_level <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshakes
	assign in_ready = !skid_vld_q;
	assign push = in_valid && in_ready;
	assign pop = head_vld_q && out_ready;

	// lanes
	for (genvar i = 0; i < ddcl_pkg::NUM_DIGITS; i++) begin : g_lane
		logic lvl;
		if (i < ddcl_pkg::BTN_LANES) begin : g_pin
			assign lvl = button_levels[i];
		end else begin : g_nopin
			assign lvl = 1'b0;
		end

		ddcl_lane u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.upd           (push && en[i]),
			.now_ms        (now_ms),
			.level         (lvl),
			.debounce_ms   (cfg_q.debounce_ms),
			.pressed_level (cfg_q.pressed_level),
			.prop          (props[i]),
			.digit         (digits[i])
		);
	end

	ddcl_merge u_merge (
		.cur   (digits),
		.props (props),
		.code  (cfg_q.code),
		.en    (en),
		.res   (res)
	);

	// output buffer: head word plus one skid word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!head_vld_q || pop) begin
			if (skid_vld_q) begin
				head_vld_q <= 1'b1;
				skid_vld_q <= push;
			end else begin
				head_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!head_vld_q || pop) begin
			if (skid_vld_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else if (push) begin
				head_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	// output fields
	assign out_valid = head_vld_q;
	assign digit_zero = head_q.digits[0];
	assign digit_one = head_q.digits[1];
	assign digit_two = head_q.digits[2];
	assign segs_zero = ddcl_pkg::seg_of(head_q.digits[0]);
	assign segs_one = ddcl_pkg::seg_of(head_q.digits[1]);
	assign segs_two = ddcl_pkg::seg_of(head_q.digits[2]);
	assign unlocked = head_q.unlocked;
	assign press_seen = head_q.press_seen;

endmodule

// ===== hdl/ddcl_lane.sv =====
// One debounce lane: stable level, last-agreement time and digit of one button.
// Proposes its digit update; commits when the merge stage enables it.
// Depends on ddcl_pkg.
module ddcl_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           upd,
	input  logic [ddcl_pkg::TIME_W-1:0]    now_ms,
	input  logic                           level,
	input  logic [ddcl_pkg::DEB_W-1:0]     debounce_ms,
	input  logic                           pressed_level,
	output ddcl_pkg::lane_prop_t           prop,
	output ddcl_pkg::digit_t               digit
);

	logic                        stable_q;
	logic [ddcl_pkg::TIME_W-1:0] agree_q;
	ddcl_pkg::digit_t            digit_q;

	logic                        differs;
	logic                        aged;
	logic [ddcl_pkg::TIME_W-1:0] elapsed;

	// age check, wrapping time difference
	assign differs = (level != stable_q);
	assign elapsed = now_ms - agree_q;
	assign aged = (elapsed >= {{(ddcl_pkg::TIME_W-ddcl_pkg::DEB_W){1'b0}}, debounce_ms});

	// proposed update
	always_comb begin
		prop.press = differs & aged & (level == pressed_level);
		if (!prop.press) begin
			prop.digit_nxt = digit_q;
		end else if (digit_q >= ddcl_pkg::DIGIT_LAST) begin
			prop.digit_nxt = '0;
		end else begin
			prop.digit_nxt = digit_q + ddcl_pkg::digit_t'(1);
		end
	end

	assign digit = digit_q;

	// lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b1;
			agree_q <= '0;
			digit_q <= '0;
		end else if (upd) begin
			if (differs) begin
				if (aged) begin
					stable_q <= level;
					digit_q <= prop.digit_nxt;
				end
			end else begin
				agree_q <= now_ms;
			end
		end
	end

endmodule

// ===== hdl/ddcl_merge.sv =====
// Merge stage: walks the lanes in order, stops at the first code match,
// and builds the result word. Depends on ddcl_pkg.
module ddcl_merge (
	input  ddcl_pkg::digits_t              cur,
	input  ddcl_pkg::lane_props_t          props,
	input  ddcl_pkg::code_t                code,
	output logic [ddcl_pkg::NUM_DIGITS-1:0] en,
	output ddcl_pkg::res_t                 res
);

	ddcl_pkg::pad_digits_t            work;
	logic [ddcl_pkg::PAD_DIGITS-1:0]  press_all;

	// lane i runs only if the digits after lanes below it miss the code
	always_comb begin
		work = '0;
		press_all = '0;
		en = '0;
		for (int i = 0; i < ddcl_pkg::NUM_DIGITS; i++) begin
			work[i] = cur[i];
		end
		for (int i = 0; i < ddcl_pkg::NUM_DIGITS; i++) begin
			en[i] = !ddcl_pkg::code_match(work, code);
			if (en[i]) begin
				work[i] = props[i].digit_nxt;
				press_all[i] = props[i].press;
			end
		end
		res.digits = work[ddcl_pkg::BTN_LANES-1:0];
		res.unlocked = ddcl_pkg::code_match(work, code);
		res.press_seen = press_all[ddcl_pkg::BTN_LANES-1:0];
	end

endmodule

// ===== hdl/ddcl_chk.sv =====
// Port-level checks for the debounced digit code lock, bound to the top.
// Depends on ddcl_pkg.
module ddcl_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] digit_zero,
	input logic [3:0] digit_one,
	input logic [3:0] digit_two,
	input logic [6:0] segs_zero,
	input logic [6:0] segs_one
);

	// digits stay decimal
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_zero <= 4'd9) && (digit_one <= 4'd9) && (digit_two <= 4'd9))
		else $error("digit out of decimal range");

	// segment patterns follow digits zero and one
	a_segs_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (segs_zero == ddcl_pkg::seg_of(digit_zero)) &&
			(segs_one == ddcl_pkg::seg_of(digit_one)))
		else $error("segment pattern does not match digit");

	// input stalls only while a result is pending
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// digits zero and two of a stalled result word hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_zero) && $stable(digit_two))
		else $error("output word changed while stalled");

endmodule

bind debounced_digit_code_lock ddcl_chk u_ddcl_chk (.*);
